@@ sv/blm_pkg.sv @@
// package for the battery low monitor: sequencer states, register codes, constants
`default_nettype none

package blm_pkg;

  // largest supported candidate bank, and its default size
  localparam int CAND_MAX     = 16;
  localparam int CAND_DEFAULT = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IDX_OUT_W  = 4;

  // fixed-point helpers
  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [41:0] RND_Q16     = 42'd32768;
  localparam logic [41:0] RND_Q15     = 42'd16384;
  localparam logic [15:0] START_LIMIT = 16'd410;
  localparam logic [23:0] OUT_POS_MAX = 24'h7FFFFF;
  localparam logic [23:0] OUT_NEG_MIN = 24'h800000;

  // register reset values
  localparam logic [15:0] LOW_THRESHOLD_RST = 16'd13926;
  localparam logic [11:0] HYSTERESIS_RST    = 12'd410;
  localparam logic [11:0] SECOND_OFFSET_RST = 12'd819;
  localparam logic [12:0] DROP_FACTOR_RST   = 13'd2048;
  localparam logic        AUTO_ENABLE_RST   = 1'b0;
  localparam logic [15:0] SMOOTH_COEFF_RST  = 16'd65326;
  localparam logic [15:0] HPF_COEFF_RST     = 16'd65480;
  localparam logic [15:0] SCORE_COEFF_RST   = 16'd65535;

  typedef enum logic [2:0] {
    REG_LOW_THRESHOLD = 3'd0,
    REG_HYSTERESIS    = 3'd1,
    REG_SECOND_OFFSET = 3'd2,
    REG_DROP_FACTOR   = 3'd3,
    REG_AUTO_ENABLE   = 3'd4,
    REG_SMOOTH_COEFF  = 3'd5,
    REG_HPF_COEFF     = 3'd6,
    REG_SCORE_COEFF   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TA0,
    S_TA1,
    S_VA0,
    S_VA1,
    S_DROP,
    S_VC,
    S_T,
    S_SC,
    S_SCW,
    S_MIN,
    S_FD,
    S_FLAG
  } state_t;

  // candidate k drop factor: round(k * 409.6) in 1/4096 V per full thrust
  localparam logic [12:0] CAND_FACTOR [CAND_MAX] = '{
    13'd0,    13'd410,  13'd819,  13'd1229,
    13'd1638, 13'd2048, 13'd2458, 13'd2867,
    13'd3277, 13'd3686, 13'd4096, 13'd4506,
    13'd4915, 13'd5325, 13'd5734, 13'd6144
  };

endpackage

`default_nettype wire

@@ sv/battery_low_monitor_core.sv @@
// battery low monitor: filtered, load-compensated voltage with two hysteresis flags
//
// usage:
//   input channel carries battery_sample and thrust_sum, taken at a clock edge
//   with in_valid high and in_stall low. one result item (low_flag,
//   very_low_flag, compensated_volts, filtered_volts, chosen_index) follows
//   every input item on the output channel, taken when out_valid is high and
//   out_stall is low.
//   configuration: cfg_we writes cfg_data into the register at cfg_index at a
//   clock edge; write only while no item is in flight.
// timing:
//   one shared 24x17 multiply-accumulate unit runs under a sequencer; the
//   argmin over the candidate scores walks one score per cycle. the sequencer
//   takes no new item until it is back in idle, which it reaches as the
//   result is loaded into the output register.
// reset:
//   rst (synchronous) restores register defaults, clears filters and the
//   candidate bank and sets both flag states; no result is pending.
// stall:
//   the result sits in an output register; a new item is still taken while it
//   waits, and the sequencer holds in its last step until the register frees.
`default_nettype none

module battery_low_monitor_core #(
  parameter int CANDIDATES = blm_pkg::CAND_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [blm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [15:0]                     battery_sample,
  input  logic [15:0]                     thrust_sum,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            low_flag,
  output logic                            very_low_flag,
  output logic [15:0]                     compensated_volts,
  output logic [15:0]                     filtered_volts,
  output logic [blm_pkg::IDX_OUT_W-1:0]   chosen_index
);
  import blm_pkg::*;

  localparam int IDX_W = $clog2(CANDIDATES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CANDIDATES - 1);

  // configuration registers
  logic [15:0] low_threshold;
  logic [11:0] hysteresis;
  logic [11:0] second_offset;
  logic [12:0] drop_factor;
  logic        auto_enable;
  logic [15:0] smooth_coeff;
  logic [15:0] hpf_coeff;
  logic [15:0] score_coeff;

  // filter and flag state
  logic [15:0] volt_avg;
  logic        primed;
  logic [15:0] thrust_avg;
  logic        low_state;
  logic        very_low_state;

  // candidate bank
  logic [15:0]        cand_last_in  [CANDIDATES];
  logic signed [23:0] cand_last_out [CANDIDATES];
  logic [23:0]        cand_score    [CANDIDATES];
  logic [IDX_W-1:0]   cand_pointer;
  logic [IDX_W-1:0]   addr;

  // working registers
  state_t             state, state_next;
  logic [15:0]        vs;
  logic [15:0]        ts;
  logic [15:0]        vc;
  logic signed [23:0] t_val;
  logic [23:0]        min_score;
  logic [IDX_W-1:0]   best;
  logic [41:0]        acc;

  // shared multiply-accumulate
  logic [23:0] mul_a;
  logic [16:0] mul_b;
  logic [41:0] acc_base;
  logic [41:0] acc_next;
  logic [40:0] prod;

  // read port of the candidate bank and derived values
  logic [15:0]        rd_last_in;
  logic signed [23:0] rd_last_out;
  logic [23:0]        rd_score;
  logic [23:0]        last_out_mag;
  logic [23:0]        t_mag;
  logic [IDX_W-1:0]   cur_k;
  logic [16:0]        smooth_rest;
  logic [16:0]        score_rest;

  // per-state combinational values
  logic [16:0]        vc_wide;
  logic [15:0]        last_in_eff;
  logic signed [25:0] scaled;
  logic signed [25:0] t_wide;
  logic [23:0]        t_sat;
  logic [12:0]        final_factor;
  logic [16:0]        sum;
  logic [16:0]        th1;
  logic [16:0]        th1_h2;
  logic signed [17:0] th2;
  logic               low_next;
  logic               very_low_next;
  logic               out_free;

  assign rd_last_in   = cand_last_in[addr];
  assign rd_last_out  = cand_last_out[addr];
  assign rd_score     = cand_score[addr];
  assign last_out_mag = rd_last_out[23] ? 24'(-rd_last_out) : 24'(rd_last_out);
  assign t_mag        = t_val[23] ? 24'(-t_val) : 24'(t_val);
  assign smooth_rest  = ONE_Q16 - {1'b0, smooth_coeff};
  assign score_rest   = ONE_Q16 - {1'b0, score_coeff};
  assign out_free     = !out_valid || !out_stall;
  assign in_stall     = (state != S_IDLE);

  // wrap a pointer that lies outside the bank
  assign cur_k = (int'(cand_pointer) >= CANDIDATES) ? '0 : cand_pointer;

  // compensated voltage of the current candidate, before saturation to 16 bits
  assign vc_wide = {1'b0, volt_avg} + 17'(acc[28:15]);

  // high-pass step of the current candidate
  always_comb begin
    last_in_eff = (rd_last_in < START_LIMIT) ? vc : rd_last_in;
    scaled      = rd_last_out[23] ? -$signed({2'b00, acc[39:16]})
                                  :  $signed({2'b00, acc[39:16]});
    t_wide      = $signed({10'b0, vc}) - $signed({10'b0, last_in_eff}) + scaled;
    if (t_wide > $signed(26'(OUT_POS_MAX))) begin
      t_sat = OUT_POS_MAX;
    end else if (t_wide < -$signed(26'(OUT_NEG_MIN))) begin
      t_sat = OUT_NEG_MIN;
    end else begin
      t_sat = t_wide[23:0];
    end
  end

  // flag decision against the thresholds, hysteresis while a flag is set
  always_comb begin
    sum           = {1'b0, volt_avg} + 17'(acc[28:15]);
    th1           = {1'b0, low_threshold} + (low_state ? {5'b0, hysteresis} : 17'd0);
    th1_h2        = {1'b0, low_threshold} + (very_low_state ? {5'b0, hysteresis} : 17'd0);
    th2           = $signed({1'b0, th1_h2}) - $signed({6'b0, second_offset});
    low_next      = sum < th1;
    very_low_next = (th2 > 18'sd0) && ($signed({1'b0, sum}) < th2);
  end

  assign final_factor = auto_enable ? CAND_FACTOR[4'(best)] : drop_factor;

  // sequencer: next state and operands of the shared unit
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    acc_base   = acc;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_TA0;
        end
      end
      S_TA0: begin
        mul_a      = 24'(thrust_avg);
        mul_b      = {1'b0, smooth_coeff};
        acc_base   = RND_Q16;
        state_next = S_TA1;
      end
      S_TA1: begin
        mul_a      = 24'(ts);
        mul_b      = smooth_rest;
        state_next = S_VA0;
      end
      S_VA0: begin
        mul_a      = 24'(volt_avg);
        mul_b      = {1'b0, smooth_coeff};
        acc_base   = RND_Q16;
        state_next = S_VA1;
      end
      S_VA1: begin
        mul_a      = 24'(vs);
        mul_b      = smooth_rest;
        state_next = S_DROP;
      end
      S_DROP: begin
        mul_a      = 24'(thrust_avg);
        mul_b      = 17'(CAND_FACTOR[4'(cur_k)]);
        acc_base   = RND_Q15;
        state_next = S_VC;
      end
      S_VC: begin
        mul_a      = last_out_mag;
        mul_b      = {1'b0, hpf_coeff};
        acc_base   = RND_Q16;
        state_next = S_T;
      end
      S_T: begin
        mul_a      = rd_score;
        mul_b      = {1'b0, score_coeff};
        acc_base   = RND_Q16;
        state_next = S_SC;
      end
      S_SC: begin
        mul_a      = t_mag;
        mul_b      = score_rest;
        state_next = S_SCW;
      end
      S_SCW: begin
        state_next = S_MIN;
      end
      S_MIN: begin
        if (addr == LAST_IDX) begin
          state_next = S_FD;
        end
      end
      S_FD: begin
        mul_a      = 24'(thrust_avg);
        mul_b      = 17'(final_factor);
        acc_base   = RND_Q15;
        state_next = S_FLAG;
      end
      S_FLAG: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign acc_next = acc_base + 42'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold <= LOW_THRESHOLD_RST;
      hysteresis    <= HYSTERESIS_RST;
      second_offset <= SECOND_OFFSET_RST;
      drop_factor   <= DROP_FACTOR_RST;
      auto_enable   <= AUTO_ENABLE_RST;
      smooth_coeff  <= SMOOTH_COEFF_RST;
      hpf_coeff     <= HPF_COEFF_RST;
      score_coeff   <= SCORE_COEFF_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOW_THRESHOLD: low_threshold <= cfg_data;
        REG_HYSTERESIS:    hysteresis    <= cfg_data[11:0];
        REG_SECOND_OFFSET: second_offset <= cfg_data[11:0];
        REG_DROP_FACTOR:   drop_factor   <= cfg_data[12:0];
        REG_AUTO_ENABLE:   auto_enable   <= cfg_data[0];
        REG_SMOOTH_COEFF:  smooth_coeff  <= cfg_data;
        REG_HPF_COEFF:     hpf_coeff     <= cfg_data;
        REG_SCORE_COEFF:   score_coeff   <= cfg_data;
      endcase
    end
  end

  // accumulator and item operands
  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (state == S_IDLE && in_valid) begin
      vs <= battery_sample;
      ts <= thrust_sum;
    end
    if (state == S_VC) begin
      vc <= vc_wide[16] ? 16'hFFFF : vc_wide[15:0];
    end
    if (state == S_T) begin
      t_val <= $signed(t_sat);
    end
    if (state == S_MIN && (addr == '0 || rd_score < min_score)) begin
      min_score <= rd_score;
      best      <= addr;
    end
  end

  // filter state, candidate bank, flags
  always_ff @(posedge clk) begin
    if (rst) begin
      volt_avg       <= '0;
      primed         <= 1'b0;
      thrust_avg     <= '0;
      low_state      <= 1'b1;
      very_low_state <= 1'b1;
      cand_pointer   <= '0;
      addr           <= '0;
      for (int i = 0; i < CANDIDATES; i++) begin
        cand_last_in[i]  <= '0;
        cand_last_out[i] <= '0;
        cand_score[i]    <= '0;
      end
    end else begin
      unique case (state)
        S_VA0: begin
          thrust_avg <= acc[31:16];
        end
        S_DROP: begin
          volt_avg <= primed ? acc[31:16] : vs;
          primed   <= 1'b1;
          addr     <= cur_k;
        end
        S_T: begin
          cand_last_in[addr]  <= vc;
          cand_last_out[addr] <= $signed(t_sat);
        end
        S_SCW: begin
          cand_score[addr] <= acc[39:16];
          cand_pointer     <= (addr == LAST_IDX) ? '0 : addr + 1'b1;
          addr             <= '0;
        end
        S_MIN: begin
          if (addr != LAST_IDX) begin
            addr <= addr + 1'b1;
          end
        end
        S_FLAG: begin
          if (out_free) begin
            low_state      <= low_next;
            very_low_state <= very_low_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FLAG && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FLAG && out_free) begin
      low_flag          <= low_next;
      very_low_flag     <= very_low_next;
      compensated_volts <= sum[16] ? 16'hFFFF : sum[15:0];
      filtered_volts    <= volt_avg;
      chosen_index      <= IDX_OUT_W'(best);
    end
  end

  // bank addresses stay inside the bank
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    int'(addr) < CANDIDATES && int'(cand_pointer) < CANDIDATES)
    else $error("candidate address outside the bank");

  // a reported index names a real candidate
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(chosen_index) < CANDIDATES)
    else $error("chosen index outside the bank");

  // compensation only adds to the filtered voltage
  a_comp_ge_filt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> compensated_volts >= filtered_volts)
    else $error("compensated voltage below filtered voltage");

  // the sequencer starts only on an accepted item
  a_start_on_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !in_valid) |=> state == S_IDLE)
    else $error("sequencer left idle without an item");

endmodule

`default_nettype wire
